@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared widths, constants and controller/datapath interface types for the
// serial clock divider search.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int unsigned REQ_W        = 31;
	localparam int unsigned CLK_W        = 31;
	localparam int unsigned BASE_W       = 29;  // clock / 4
	localparam int unsigned DIV_W        = 15;  // (d+1)*p <= 256*127
	localparam int unsigned P_W          = 7;
	localparam int unsigned D_W          = 8;
	localparam int unsigned ADDR_W       = 3;
	localparam int unsigned DATA_W       = 32;

	localparam int unsigned MAX_DIVIDER  = 255;
	localparam int unsigned MAX_PRESCALE = 127;

	localparam logic [CLK_W-1:0] SYS_CLK_RESET = CLK_W'(100000000);

	// register indexes
	localparam logic REG_SYS_CLK = 1'b0;

	typedef struct packed {
		logic start;  // latch request, clear search state
		logic issue;  // push current pair into the divider pipe
		logic load;   // move the winner into the output register
	} scd_cmd_t;

	typedef struct packed {
		logic last_pair;
		logic pipe_empty;
		logic out_free;
	} scd_status_t;

endpackage

@@ rtl/spi_clock_divider_search_core.sv @@
// ----------------------------------------------------------------------------
// spi_clock_divider_search_core
// Finds the prescale / divider pair whose serial clock rate lies closest to
// a requested rate.
// ----------------------------------------------------------------------------
//  channel   signals                               transaction
//  input     in_valid, in_stall, requested_rate    one request
//  output    out_valid, out_stall, clock_prescale, one winning pair
//            serial_divider
//  config    psel, penable, pwrite, paddr, pwdata, register write / read
//            prdata, pready
//
//  one pair enters the divider pipe per cycle: the pair counter issues 24,511
//  pairs, which pass through the 29 one-bit-per-stage divider stages and
//  drain from the pipe before the winner is loaded into the output register
//  one request at a time; the next is taken while a result waits in the
//  output register, and a stalled result holds the finishing search
//  asynchronous reset clears control state and loads the clock register
// ----------------------------------------------------------------------------
module spi_clock_divider_search_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [scd_pkg::REQ_W-1:0]   requested_rate,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scd_pkg::P_W-1:0]     clock_prescale,
	output logic [scd_pkg::D_W-1:0]     serial_divider,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scd_pkg::ADDR_W-1:0]  paddr,
	input  logic [scd_pkg::DATA_W-1:0]  pwdata,
	output logic [scd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import scd_pkg::*;

	logic [CLK_W-1:0] sys_clk_hz;
	scd_cmd_t         cmd;
	scd_status_t      status;

	scd_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.sys_clk_hz (sys_clk_hz)
	);

	scd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	scd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.requested_rate (requested_rate),
		.sys_clk_hz     (sys_clk_hz),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.clock_prescale (clock_prescale),
		.serial_divider (serial_divider)
	);

endmodule

@@ rtl/scd_regs.sv @@
// ----------------------------------------------------------------------------
// scd_regs
// APB-style register file holding the system clock frequency.
// ----------------------------------------------------------------------------
module scd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scd_pkg::ADDR_W-1:0]  paddr,
	input  logic [scd_pkg::DATA_W-1:0]  pwdata,
	output logic [scd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [scd_pkg::CLK_W-1:0]   sys_clk_hz
);
	import scd_pkg::*;

	logic [CLK_W-1:0] sys_clk_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SYS_CLK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_clk_q <= SYS_CLK_RESET;
		end else if (wr_en) begin
			sys_clk_q <= pwdata[CLK_W-1:0];
		end
	end

	assign prdata     = (paddr[2] == REG_SYS_CLK) ? DATA_W'(sys_clk_q) : '0;
	assign sys_clk_hz = sys_clk_q;

endmodule

@@ rtl/scd_ctrl.sv @@
// ----------------------------------------------------------------------------
// scd_ctrl
// Search sequencer: issues every divider pair, drains the divider pipe and
// hands the winner to the output register.
// ----------------------------------------------------------------------------
module scd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  scd_pkg::scd_status_t status,
	output scd_pkg::scd_cmd_t    cmd
);
	import scd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (status.last_pair) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.pipe_empty) begin
					if (status.out_free) begin
						cmd.load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d  = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/scd_datapath.sv @@
// ----------------------------------------------------------------------------
// scd_datapath
// Pair counters, divisor multiplier, bit-per-stage restoring divider pipe,
// error stage, best-pair tracking and output register.
// ----------------------------------------------------------------------------
module scd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [scd_pkg::REQ_W-1:0]   requested_rate,
	input  logic [scd_pkg::CLK_W-1:0]   sys_clk_hz,
	input  scd_pkg::scd_cmd_t           cmd,
	output scd_pkg::scd_status_t        status,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [scd_pkg::P_W-1:0]     clock_prescale,
	output logic [scd_pkg::D_W-1:0]     serial_divider
);
	import scd_pkg::*;

	// search operands
	logic [REQ_W-1:0]  req_q;
	logic [BASE_W-1:0] base_q;

	// pair counters
	logic [D_W-1:0]    d_q;
	logic [P_W-1:0]    p_q;
	logic [D_W-1:0]    p_lim;
	logic              p_wrap;
	logic [DIV_W:0]    prod;

	// stage 1: divisor
	logic              valid_s1;
	logic [DIV_W-1:0]  div_s1;
	logic [P_W-1:0]    p_s1;
	logic [D_W-1:0]    d_s1;

	// stage 2: one quotient bit per entry
	logic [BASE_W-1:0] dv_valid_s2;
	logic [DIV_W-1:0]  dv_rem_s2 [BASE_W];
	logic [DIV_W-1:0]  dv_div_s2 [BASE_W];
	logic [BASE_W-1:0] dv_quo_s2 [BASE_W];
	logic [P_W-1:0]    dv_p_s2   [BASE_W];
	logic [D_W-1:0]    dv_d_s2   [BASE_W];

	logic [DIV_W:0]    trial  [BASE_W];
	logic [DIV_W-1:0]  sdiv   [BASE_W];
	logic [BASE_W-1:0] squo   [BASE_W];
	logic              ge     [BASE_W];
	logic [DIV_W-1:0]  nx_rem [BASE_W];
	logic [BASE_W-1:0] nx_quo [BASE_W];

	// stage 3: error
	logic              valid_s3;
	logic [REQ_W-1:0]  err_s3;
	logic [P_W-1:0]    p_s3;
	logic [D_W-1:0]    d_s3;
	logic [REQ_W-1:0]  got;
	logic [REQ_W-1:0]  err_d;

	// best so far
	logic              best_have_q;
	logic [REQ_W-1:0]  best_err_q;
	logic [P_W-1:0]    best_p_q;
	logic [D_W-1:0]    best_d_q;

	// output register
	logic              out_valid_q;
	logic [P_W-1:0]    out_p_q;
	logic [D_W-1:0]    out_d_q;

	// prescale runs 1..min(d+1, 127)
	assign p_lim  = (d_q >= D_W'(MAX_PRESCALE)) ? D_W'(MAX_PRESCALE) : d_q + D_W'(1);
	assign p_wrap = ({1'b0, p_q} == p_lim);
	assign prod   = (DIV_W+1)'(({8'd0, d_q} + 16'd1) * {9'd0, p_q});

	assign status.last_pair  = p_wrap && (d_q == D_W'(MAX_DIVIDER));
	assign status.pipe_empty = !valid_s1 && !(|dv_valid_s2) && !valid_s3;
	assign status.out_free   = !out_valid_q || !out_stall;

	always_comb begin
		for (int k = 0; k < BASE_W; k++) begin
			if (k == 0) begin
				trial[k] = {{DIV_W{1'b0}}, base_q[BASE_W-1]};
				sdiv[k]  = div_s1;
				squo[k]  = '0;
			end else begin
				trial[k] = {dv_rem_s2[k-1], base_q[BASE_W-1-k]};
				sdiv[k]  = dv_div_s2[k-1];
				squo[k]  = dv_quo_s2[k-1];
			end
			ge[k]     = (trial[k] >= {1'b0, sdiv[k]});
			// remainder stays below the divisor, so it fits DIV_W bits
			nx_rem[k] = ge[k] ? DIV_W'(trial[k] - {1'b0, sdiv[k]}) : trial[k][DIV_W-1:0];
			nx_quo[k] = {squo[k][BASE_W-2:0], ge[k]};
		end
	end

	assign got   = REQ_W'(dv_quo_s2[BASE_W-1]);
	assign err_d = (req_q > got) ? (req_q - got) : (got - req_q);

	// control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dv_valid_s2 <= '0;
			valid_s3    <= 1'b0;
			best_have_q <= 1'b0;
			out_valid_q <= 1'b0;
			d_q         <= '0;
			p_q         <= P_W'(1);
		end else begin
			valid_s1    <= cmd.issue;
			dv_valid_s2 <= {dv_valid_s2[BASE_W-2:0], valid_s1};
			valid_s3    <= dv_valid_s2[BASE_W-1];
			if (cmd.start) begin
				best_have_q <= 1'b0;
				d_q         <= '0;
				p_q         <= P_W'(1);
			end else begin
				if (valid_s3 && (!best_have_q || (err_s3 < best_err_q))) begin
					best_have_q <= 1'b1;
				end
				if (cmd.issue) begin
					if (p_wrap) begin
						p_q <= P_W'(1);
						d_q <= d_q + D_W'(1);
					end else begin
						p_q <= p_q + P_W'(1);
					end
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload flops
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= requested_rate;
			base_q <= sys_clk_hz[CLK_W-1:2];
		end
		div_s1 <= prod[DIV_W-1:0];
		p_s1   <= p_q;
		d_s1   <= d_q;
		for (int k = 0; k < BASE_W; k++) begin
			dv_rem_s2[k] <= nx_rem[k];
			dv_div_s2[k] <= sdiv[k];
			dv_quo_s2[k] <= nx_quo[k];
			dv_p_s2[k]   <= (k == 0) ? p_s1 : dv_p_s2[(k == 0) ? 0 : k-1];
			dv_d_s2[k]   <= (k == 0) ? d_s1 : dv_d_s2[(k == 0) ? 0 : k-1];
		end
		err_s3 <= err_d;
		p_s3   <= dv_p_s2[BASE_W-1];
		d_s3   <= dv_d_s2[BASE_W-1];
		// strict less keeps the earliest pair on a tie
		if (valid_s3 && (!best_have_q || (err_s3 < best_err_q))) begin
			best_err_q <= err_s3;
			best_p_q   <= p_s3;
			best_d_q   <= d_s3;
		end
		if (cmd.load) begin
			out_p_q <= best_p_q;
			out_d_q <= best_d_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign clock_prescale = out_p_q;
	assign serial_divider = out_d_q;

endmodule

@@ rtl/scd_checker.sv @@
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks on the divider search core, bound to the top level.
// ----------------------------------------------------------------------------
module scd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [scd_pkg::P_W-1:0]     clock_prescale,
	input logic [scd_pkg::D_W-1:0]     serial_divider
);
	import scd_pkg::*;

	// an accepted request keeps the search busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transaction");

	// winning prescale is never zero and never above divider + 1
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (clock_prescale != '0) &&
			({1'b0, serial_divider} + 9'd1 >= {2'b0, clock_prescale}))
		else $error("result pair outside the search space");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(clock_prescale) && $stable(serial_divider))
		else $error("stalled result changed");

endmodule

bind spi_clock_divider_search_core scd_checker u_scd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.clock_prescale (clock_prescale),
	.serial_divider (serial_divider)
);

@@ tb/divider_search_checker.sv @@
// ----------------------------------------------------------------------------
// divider_search_checker
// Watches the request, result and register channels of the divider search.
// Keeps its own copy of the clock register, works out the winning prescale /
// divider pair for every accepted request, and compares each result with the
// oldest pending pair. Register reads are checked against the same copy.
// ----------------------------------------------------------------------------
module divider_search_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [scd_pkg::REQ_W-1:0]  requested_rate,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [scd_pkg::P_W-1:0]    clock_prescale,
	input  logic [scd_pkg::D_W-1:0]    serial_divider,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [scd_pkg::ADDR_W-1:0] paddr,
	input  logic [scd_pkg::DATA_W-1:0] pwdata,
	input  logic [scd_pkg::DATA_W-1:0] prdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import scd_pkg::*;

	typedef struct packed {
		logic [P_W-1:0] prescale;
		logic [D_W-1:0] divider;
	} divider_pair_t;

	logic [CLK_W-1:0] sys_clk_hz;
	divider_pair_t    pending_pairs[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 30)
			$display("%0t ns: %s", $time, msg);
	endtask

	// exhaustive search over all divider / prescale pairs, first best wins
	function automatic divider_pair_t closest_pair(input logic [CLK_W-1:0] hz,
			input logic [REQ_W-1:0] rate);
		longint unsigned base;
		longint unsigned got;
		longint unsigned err;
		longint unsigned best_err;
		longint unsigned want;
		int unsigned plim;
		divider_pair_t best;
		base = longint'(hz) / 4;
		want = longint'(rate);
		best_err = '1;
		best.prescale = P_W'(1);
		best.divider = '0;
		for (int unsigned d = 0; d <= MAX_DIVIDER; d++) begin
			plim = (d + 1 > MAX_PRESCALE) ? MAX_PRESCALE : d + 1;
			for (int unsigned p = 1; p <= plim; p++) begin
				got = base / longint'((d + 1) * p);
				err = (want > got) ? want - got : got - want;
				if (err < best_err) begin
					best_err = err;
					best.prescale = P_W'(p);
					best.divider = D_W'(d);
				end
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		divider_pair_t exp_pair;
		if (!arst_n) begin
			sys_clk_hz = SYS_CLK_RESET;
			pending_pairs.delete();
		end else begin
			// results first so a request taken on the same edge cannot hide a stray one
			if (out_valid && !out_stall) begin
				if (pending_pairs.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: prescale %0d divider %0d",
						clock_prescale, serial_divider));
				end else begin
					exp_pair = pending_pairs.pop_front();
					if (clock_prescale !== exp_pair.prescale)
						report_mismatch($sformatf("clock_prescale %0d, want %0d",
							clock_prescale, exp_pair.prescale));
					if (serial_divider !== exp_pair.divider)
						report_mismatch($sformatf("serial_divider %0d, want %0d",
							serial_divider, exp_pair.divider));
				end
			end
			if (in_valid && !in_stall)
				pending_pairs.push_back(closest_pair(sys_clk_hz, requested_rate));
			if (psel && penable && pready && (paddr >> 2) == ADDR_W'(REG_SYS_CLK)) begin
				if (pwrite)
					sys_clk_hz = pwdata[CLK_W-1:0];
				else if (prdata !== DATA_W'(sys_clk_hz))
					report_mismatch($sformatf("clock register reads %0d, want %0d",
						prdata, sys_clk_hz));
			end
		end
		pending = pending_pairs.size();
	end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives requested rates and clock register settings into the divider search
// core with random gaps and result back-pressure; the checker beside the core
// predicts every winning pair and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scd_pkg::*;

	localparam logic [ADDR_W-1:0] SYS_CLK_ADDR = ADDR_W'(REG_SYS_CLK) << 2;
	localparam logic [ADDR_W-1:0] NO_REG_ADDR  = ADDR_W'(4);
	localparam longint            RUN_LIMIT_NS = 64'd60_000_000;

	logic              clk;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic [REQ_W-1:0]  requested_rate = '0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	logic [P_W-1:0]    clock_prescale;
	logic [D_W-1:0]    serial_divider;
	logic              psel           = 1'b0;
	logic              penable        = 1'b0;
	logic              pwrite         = 1'b0;
	logic [ADDR_W-1:0] paddr          = '0;
	logic [DATA_W-1:0] pwdata         = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int                fail_count;
	int                pending;
	int unsigned       send_pct = 26;
	int unsigned       recv_pct = 77;
	logic [CLK_W-1:0]  cur_clk  = SYS_CLK_RESET;

	spi_clock_divider_search_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.requested_rate (requested_rate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.clock_prescale (clock_prescale),
		.serial_divider (serial_divider),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	divider_search_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.requested_rate (requested_rate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.clock_prescale (clock_prescale),
		.serial_divider (serial_divider),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_pct);
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// valid stays up between back-to-back requests; it is lowered only for a random gap here or in wait_idle
	task automatic send_request(input logic [REQ_W-1:0] rate);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		requested_rate <= rate;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_clock(input logic [DATA_W-1:0] value);
		wait_idle();
		reg_access(1'b1, SYS_CLK_ADDR, value);
		cur_clk = value[CLK_W-1:0];
		reg_access(1'b0, SYS_CLK_ADDR, '0);
	endtask

	function automatic logic [DATA_W-1:0] pick_clock();
		case ($urandom_range(2))
			0: return $urandom_range(200_000_000, 1_000_000);
			1: return $urandom;
			default: return $urandom_range(64);
		endcase
	endfunction

	// rates near what the dividers can reach, mixed with random ones, so ties and close calls show up
	function automatic logic [REQ_W-1:0] pick_rate(input int unsigned base);
		int unsigned k;
		logic [31:0] r;
		case ($urandom_range(4))
			0: r = $urandom;
			1: r = $urandom >> $urandom_range(31);
			2: begin
				k = $urandom_range(32512, 1);
				r = base / k + $urandom_range(4) - 2;
			end
			3: begin
				k = $urandom_range(32511, 1);
				r = (base / k + base / (k + 1)) / 2;
			end
			default: r = $urandom_range(1000);
		endcase
		return r[REQ_W-1:0];
	endfunction

	initial begin
		logic [REQ_W-1:0] reset_rates[13];
		logic [REQ_W-1:0] max_clk_rates[4];
		reset_rates = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd25_000_000, 31'd25_000_001,
			31'd768, 31'd700, 31'd12_500_000, 31'd18_750_000, 31'd100_000,
			31'd1_234_567, 31'h5555_5555, 31'h2AAA_AAAA};
		max_clk_rates = '{31'd0, 31'd536_870_911, 31'd1, 31'h7FFF_FFFF};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// reset value of the clock register, then requests against it
		reg_access(1'b0, SYS_CLK_ADDR, '0);
		foreach (reset_rates[i])
			send_request(reset_rates[i]);

		// base clock of zero: every pair ties
		set_clock(32'd3);
		send_request(31'd0);
		send_request(31'd9999);
		send_request(31'h7FFF_FFFF);
		set_clock(32'd0);
		send_request(31'd5);

		set_clock(32'h7FFF_FFFF);
		foreach (max_clk_rates[i])
			send_request(max_clk_rates[i]);

		set_clock(32'd4);
		send_request(31'd0);
		send_request(31'd1);
		send_request(31'd2);

		// top bit of the write data is not part of the register
		set_clock(32'h8000_0000 | 32'd48_000_000);
		send_request(31'd1_000_000);
		send_request(31'd3_000_000);

		// write outside the register map must leave the clock alone
		wait_idle();
		reg_access(1'b1, NO_REG_ADDR, 32'hFFFF_FFFF);
		reg_access(1'b0, SYS_CLK_ADDR, '0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_pct = 26;
					recv_pct = 77;
				end
				1: begin
					send_pct = 77;
					recv_pct = 26;
				end
				default: begin
					send_pct = 0;
					recv_pct = 0;
				end
			endcase
			for (int sub = 0; sub < 2; sub++) begin
				set_clock(pick_clock());
				repeat (13)
					send_request(pick_rate(cur_clk / 4));
			end
		end

		wait_idle();
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
